### rtl/core/perspective_warp_bilinear_assert.svh
// Assertion macros shared by the warp block.
`ifndef PERSPECTIVE_WARP_BILINEAR_ASSERT_SVH
`define PERSPECTIVE_WARP_BILINEAR_ASSERT_SVH
`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset.
`define PWB_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Condition must never be true at a clock edge outside reset.
`define PWB_NEVER(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define PWB_ASSERT(lbl, clk, rst, prop, msg)
`define PWB_NEVER(lbl, clk, rst, cond, msg)
`endif
`endif

### rtl/core/pwb_pkg.sv
package pwb_pkg;

   localparam int COEF_W     = 32;
   localparam int POS_W      = 6;
   localparam int CHAN_W     = 8;
   localparam int PIX_W      = 3 * CHAN_W;
   localparam int FRAME_W    = 7;
   localparam int PROD_W     = COEF_W + POS_W + 1;
   localparam int GEO_W      = PROD_W + 2;
   localparam int DIV_W      = GEO_W - 1;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 64;
   localparam int NUM_COEF   = 9;
   localparam int Q_DEPTH    = 4;

   localparam int DEF_MAX_WIDTH       = 64;
   localparam int DEF_MAX_HEIGHT      = 64;
   localparam int DEF_RECIP_FRAC_BITS = 16;

   localparam logic [CSR_DATA_W-1:0] RST_COEF_A    = 64'h0000_0001_0000_0000;
   localparam logic [CSR_DATA_W-1:0] RST_COEF_B    = 64'h0;
   localparam logic [CSR_DATA_W-1:0] RST_COEF_C    = 64'h1;
   localparam logic [CSR_DATA_W-1:0] RST_COEF_D    = 64'h0;
   localparam logic [COEF_W-1:0]     RST_COEF_LAST = 32'h1;
   localparam logic [FRAME_W-1:0]    RST_FRAME     = 7'd64;

   localparam logic KIND_LOAD    = 1'b0;
   localparam logic KIND_COMPUTE = 1'b1;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_COEF_A    = 3'd0,
      REG_COEF_B    = 3'd1,
      REG_COEF_C    = 3'd2,
      REG_COEF_D    = 3'd3,
      REG_COEF_LAST = 3'd4,
      REG_FRAME_W   = 3'd5,
      REG_FRAME_H   = 3'd6
   } pwb_reg_type;

   // Per-entry control carried from front to back.
   typedef struct packed {
      logic kind;   // load or compute
      logic ok;     // all four neighbors inside the frame
      logic we;     // load lands inside the store
   } pwb_flags_type;

   // Signed coefficient times unsigned pixel position, full width.
   function automatic logic signed [PROD_W-1:0] mul_cp(logic signed [COEF_W-1:0] m,
                                                       logic [POS_W-1:0] p);
      logic signed [PROD_W-1:0] me;
      logic signed [PROD_W-1:0] pe;
      me = PROD_W'(m);
      pe = $signed({{(PROD_W - POS_W){1'b0}}, p});
      return me * pe;
   endfunction

endpackage

### rtl/core/pwb_ram.sv
module pwb_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 4096,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/core/pwb_div.sv
module pwb_div import pwb_pkg::*; #(
   parameter int DW = DIV_W,
   parameter int QW = 17
) (
   input  logic          clock,
   input  logic          enable,
   input  logic [DW-1:0] dividend,
   input  logic [DW-1:0] divisor,
   output logic [QW-1:0] quotient,
   output logic [DW-1:0] remainder,
   output logic [DW-1:0] divisor_out,
   output logic          overflow
);

   localparam int EW = DW + QW;

   logic [EW-1:0] rem_ff [QW+1];
   logic [DW-1:0] dsr_ff [QW+1];
   logic [QW-1:0] quo_ff [QW+1];
   logic          ovf_ff [QW+1];

   // Load the first stage and flag quotients that do not fit in QW bits.
   always_ff @(posedge clock) begin
      if (enable) begin
         rem_ff[0] <= EW'(dividend);
         dsr_ff[0] <= divisor;
         quo_ff[0] <= '0;
         ovf_ff[0] <= EW'(dividend) >= (EW'(divisor) << QW);
      end
   end

   // One restoring step per stage, most significant quotient bit first.
   for (genvar s = 0; s < QW; s++) begin : g_step
      localparam int B = QW - 1 - s;
      logic [EW-1:0] shd;
      logic          ge;
      logic [EW-1:0] rem_in;
      logic [QW-1:0] quo_in;

      always_comb begin
         shd       = EW'(dsr_ff[s]) << B;
         ge        = rem_ff[s] >= shd;
         rem_in    = ge ? rem_ff[s] - shd : rem_ff[s];
         quo_in    = quo_ff[s];
         quo_in[B] = ge;
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            rem_ff[s+1] <= rem_in;
            dsr_ff[s+1] <= dsr_ff[s];
            quo_ff[s+1] <= quo_in;
            ovf_ff[s+1] <= ovf_ff[s];
         end
      end
   end

   assign quotient    = quo_ff[QW];
   assign remainder   = rem_ff[QW][DW-1:0];
   assign divisor_out = dsr_ff[QW];
   assign overflow    = ovf_ff[QW];

endmodule

### rtl/core/pwb_front.sv
module pwb_front import pwb_pkg::*; #(
   parameter int MAX_WIDTH       = DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT      = DEF_MAX_HEIGHT,
   parameter int RECIP_FRAC_BITS = DEF_RECIP_FRAC_BITS,
   localparam int AW     = $clog2(MAX_WIDTH * MAX_HEIGHT),
   localparam int FW     = RECIP_FRAC_BITS + 1,
   localparam int DATA_W = 5 * AW + PIX_W + 5 * FW
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               enable,
   input  logic                               in_valid,
   input  logic                               in_kind,
   input  logic [POS_W-1:0]                   in_row,
   input  logic [POS_W-1:0]                   in_col,
   input  logic [PIX_W-1:0]                   in_pixel,
   input  logic [NUM_COEF-1:0][COEF_W-1:0]    coef,
   input  logic [FRAME_W-1:0]                 frame_width,
   input  logic [FRAME_W-1:0]                 frame_height,
   output logic                               out_valid,
   output pwb_flags_type                      out_flags,
   output logic [DATA_W-1:0]                  out_data
);

   localparam int XW  = $clog2(MAX_WIDTH);
   localparam int YW  = $clog2(MAX_HEIGHT);
   localparam int QW0 = (XW > YW) ? XW : YW;
   localparam int QW  = (FW > QW0) ? FW : QW0;
   localparam int CW  = QW + 8;
   localparam int SW  = 5 + AW + PIX_W;
   localparam logic [DIV_W-1:0] RECIP_ONE = DIV_W'(1) << RECIP_FRAC_BITS;

   function automatic logic [AW-1:0] addr_of(logic [QW:0] yy, logic [QW:0] xx);
      return AW'(yy) * AW'(MAX_WIDTH) + AW'(xx);
   endfunction

   // Stage 1: products of the homography
   logic                     v1_ff;
   logic                     kind1_ff;
   logic                     we1_ff;
   logic [AW-1:0]            waddr1_ff;
   logic [PIX_W-1:0]         pix1_ff;
   logic signed [PROD_W-1:0] pxc_ff, pxr_ff, pyc_ff, pyr_ff, pzc_ff, pzr_ff;
   logic                     we1_in;

   assign we1_in = (in_kind == KIND_LOAD) && (CW'(in_row) < CW'(MAX_HEIGHT))
                   && (CW'(in_col) < CW'(MAX_WIDTH));

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (enable) begin
         v1_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         kind1_ff  <= in_kind;
         we1_ff    <= we1_in;
         waddr1_ff <= AW'(in_row) * AW'(MAX_WIDTH) + AW'(in_col);
         pix1_ff   <= in_pixel;
         pxc_ff    <= mul_cp($signed(coef[0]), in_col);
         pxr_ff    <= mul_cp($signed(coef[1]), in_row);
         pyc_ff    <= mul_cp($signed(coef[3]), in_col);
         pyr_ff    <= mul_cp($signed(coef[4]), in_row);
         pzc_ff    <= mul_cp($signed(coef[6]), in_col);
         pzr_ff    <= mul_cp($signed(coef[7]), in_row);
      end
   end

   // Stage 2: sums x, y, z
   logic                    v2_ff;
   logic                    kind2_ff;
   logic                    we2_ff;
   logic [AW-1:0]           waddr2_ff;
   logic [PIX_W-1:0]        pix2_ff;
   logic signed [GEO_W-1:0] x_ff, y_ff, z_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (enable) begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         kind2_ff  <= kind1_ff;
         we2_ff    <= we1_ff;
         waddr2_ff <= waddr1_ff;
         pix2_ff   <= pix1_ff;
         x_ff <= GEO_W'(pxc_ff) + GEO_W'(pxr_ff) + GEO_W'($signed(coef[2]));
         y_ff <= GEO_W'(pyc_ff) + GEO_W'(pyr_ff) + GEO_W'($signed(coef[5]));
         z_ff <= GEO_W'(pzc_ff) + GEO_W'(pzr_ff) + GEO_W'($signed(coef[8]));
      end
   end

   // Division pipeline: x/z, y/z and the reciprocal of z side by side
   logic             xpos, ypos, zpos;
   logic             dv_ff   [QW+1];
   logic [SW-1:0]    side_ff [QW+1];
   logic [QW-1:0]    qx, qy, qr;
   logic [DIV_W-1:0] rx, ry, dz;
   logic             ovx, ovy, ovr;

   assign xpos = !x_ff[GEO_W-1] && (x_ff != '0);
   assign ypos = !y_ff[GEO_W-1] && (y_ff != '0);
   assign zpos = !z_ff[GEO_W-1] && (z_ff != '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s <= QW; s++) begin
            dv_ff[s] <= 1'b0;
         end
      end else if (enable) begin
         dv_ff[0] <= v2_ff;
         for (int s = 1; s <= QW; s++) begin
            dv_ff[s] <= dv_ff[s-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         side_ff[0] <= {kind2_ff, we2_ff, xpos, ypos, zpos, waddr2_ff, pix2_ff};
         for (int s = 1; s <= QW; s++) begin
            side_ff[s] <= side_ff[s-1];
         end
      end
   end

   pwb_div #(.DW(DIV_W), .QW(QW)) u_div_x (
      .clock       (clock),
      .enable      (enable),
      .dividend    (x_ff[DIV_W-1:0]),
      .divisor     (z_ff[DIV_W-1:0]),
      .quotient    (qx),
      .remainder   (rx),
      .divisor_out (dz),
      .overflow    (ovx)
   );

   pwb_div #(.DW(DIV_W), .QW(QW)) u_div_y (
      .clock       (clock),
      .enable      (enable),
      .dividend    (y_ff[DIV_W-1:0]),
      .divisor     (z_ff[DIV_W-1:0]),
      .quotient    (qy),
      .remainder   (ry),
      .divisor_out (),
      .overflow    (ovy)
   );

   pwb_div #(.DW(DIV_W), .QW(QW)) u_div_r (
      .clock       (clock),
      .enable      (enable),
      .dividend    (RECIP_ONE),
      .divisor     (z_ff[DIV_W-1:0]),
      .quotient    (qr),
      .remainder   (),
      .divisor_out (),
      .overflow    (ovr)
   );

   // Final stage: bounds check and store addresses
   logic             s_kind, s_we, s_xpos, s_ypos, s_zpos;
   logic [AW-1:0]    s_waddr;
   logic [PIX_W-1:0] s_pix;
   logic [QW:0]      x1, y1, x2, y2;
   logic [DIV_W-1:0] dx2, dy2;
   logic [CW-1:0]    w_use, h_use;
   logic             ok_in;

   assign {s_kind, s_we, s_xpos, s_ypos, s_zpos, s_waddr, s_pix} = side_ff[QW];

   always_comb begin
      x1    = (QW+1)'(qx);
      y1    = (QW+1)'(qy);
      x2    = x1 + (QW+1)'(rx != '0);
      y2    = y1 + (QW+1)'(ry != '0);
      dx2   = dz - rx;
      dy2   = dz - ry;
      w_use = (CW'(frame_width) > CW'(MAX_WIDTH)) ? CW'(MAX_WIDTH) : CW'(frame_width);
      h_use = (CW'(frame_height) > CW'(MAX_HEIGHT)) ? CW'(MAX_HEIGHT) : CW'(frame_height);
      ok_in = s_zpos && s_xpos && s_ypos && !ovx && !ovy && !ovr
              && (x1 != '0) && (CW'(x2) < w_use)
              && (y1 != '0) && (CW'(y2) < h_use);
   end

   logic                out_v_ff;
   pwb_flags_type       flags_ff;
   logic [DATA_W-1:0]   data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (enable) begin
         out_v_ff <= dv_ff[QW];
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         flags_ff <= '{kind: s_kind, ok: ok_in, we: s_we};
         data_ff  <= {addr_of(y1, x1), addr_of(y1, x2), addr_of(y2, x1), addr_of(y2, x2),
                      s_waddr, s_pix,
                      FW'(rx), FW'(dx2), FW'(ry), FW'(dy2), FW'(qr)};
      end
   end

   assign out_valid = out_v_ff;
   assign out_flags = flags_ff;
   assign out_data  = data_ff;

endmodule

### rtl/core/pwb_queue.sv
module pwb_queue import pwb_pkg::*; #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int PW = $clog2(Q_DEPTH);

   logic [WIDTH-1:0] slot_ff [Q_DEPTH];
   logic [PW-1:0]    wr_ptr_ff, rd_ptr_ff;
   logic [PW:0]      count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_data = slot_ff[rd_ptr_ff];
   assign full     = (count_ff == (PW+1)'(Q_DEPTH));
   assign empty    = (count_ff == '0);

`include "perspective_warp_bilinear_assert.svh"
   `PWB_NEVER(a_push_full, clock, reset, push && full, "push into full queue")
   `PWB_NEVER(a_pop_empty, clock, reset, pop && empty, "pop from empty queue")

endmodule

### rtl/core/pwb_back.sv
module pwb_back import pwb_pkg::*; #(
   parameter int MAX_WIDTH       = DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT      = DEF_MAX_HEIGHT,
   parameter int RECIP_FRAC_BITS = DEF_RECIP_FRAC_BITS,
   localparam int AW     = $clog2(MAX_WIDTH * MAX_HEIGHT),
   localparam int FW     = RECIP_FRAC_BITS + 1,
   localparam int DATA_W = 5 * AW + PIX_W + 5 * FW
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  pwb_flags_type     in_flags,
   input  logic [DATA_W-1:0] in_data,
   output logic              in_pop,
   output logic              out_valid,
   input  logic              out_ready,
   output logic              out_ok,
   output logic [CHAN_W-1:0] out_red,
   output logic [CHAN_W-1:0] out_green,
   output logic [CHAN_W-1:0] out_blue
);

   localparam int PW = FW + CHAN_W;       // dx times pixel
   localparam int SW = PW + 1;            // sum of two
   localparam int RW = FW + SW;           // reciprocal times sum

   logic [AW-1:0]    raddr [4];
   logic [AW-1:0]    waddr;
   logic [PIX_W-1:0] pix;
   logic [FW-1:0]    dx1, dx2, dy1, dy2, rcp;

   assign {raddr[0], raddr[1], raddr[2], raddr[3], waddr, pix,
           dx1, dx2, dy1, dy2, rcp} = in_data;

   logic en;
   logic pop;
   logic rsp_valid_ff;

   // Advance whenever the output register is free or being drained.
   assign en  = !rsp_valid_ff || out_ready;
   assign pop = en && in_valid;

   // Four copies of the store, one read port each; loads write all four.
   logic [PIX_W-1:0] px_q [4];

   for (genvar k = 0; k < 4; k++) begin : g_store
      pwb_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH * MAX_HEIGHT)) u_ram (
         .clock   (clock),
         .wr_en   (pop && in_flags.we),
         .wr_addr (waddr),
         .wr_data (pix),
         .rd_en   (en),
         .rd_addr (raddr[k]),
         .rd_data (px_q[k])
      );
   end

   // Control and shared operands along the back pipeline
   logic          v_ff    [1:7];
   logic          kind_ff [1:7];
   logic          ok_ff   [1:7];
   logic [FW-1:0] rcp_ff  [1:6];
   logic [FW-1:0] dy1_ff  [1:4];
   logic [FW-1:0] dy2_ff  [1:4];
   logic [FW-1:0] dx1_ff, dx2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 1; s <= 7; s++) begin
            v_ff[s] <= 1'b0;
         end
      end else if (en) begin
         v_ff[1] <= pop;
         for (int s = 2; s <= 7; s++) begin
            v_ff[s] <= v_ff[s-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         kind_ff[1] <= in_flags.kind;
         ok_ff[1]   <= in_flags.ok;
         rcp_ff[1]  <= rcp;
         dy1_ff[1]  <= dy1;
         dy2_ff[1]  <= dy2;
         dx1_ff     <= dx1;
         dx2_ff     <= dx2;
         for (int s = 2; s <= 7; s++) begin
            kind_ff[s] <= kind_ff[s-1];
            ok_ff[s]   <= ok_ff[s-1];
         end
         for (int s = 2; s <= 6; s++) begin
            rcp_ff[s] <= rcp_ff[s-1];
         end
         for (int s = 2; s <= 4; s++) begin
            dy1_ff[s] <= dy1_ff[s-1];
            dy2_ff[s] <= dy2_ff[s-1];
         end
      end
   end

   // One lane per color channel
   logic [CHAN_W-1:0] chan_out [3];

   for (genvar c = 0; c < 3; c++) begin : g_chan
      localparam int SH = PIX_W - CHAN_W * (c + 1);
      logic [PW-1:0]     pr_ff [4];
      logic [SW-1:0]     sm_ff [2];
      logic [RW-1:0]     rp_ff [2];
      logic [PW-1:0]     dp_ff [2];
      logic [SW-1:0]     s2_ff;
      logic [RW-1:0]     r_ff;
      logic [CHAN_W-1:0] t1, t2;
      logic [CHAN_W:0]   r_top;
      logic [CHAN_W-1:0] sat;
      logic [CHAN_W-1:0] chan_ff;

      assign t1    = rp_ff[0][RECIP_FRAC_BITS +: CHAN_W];
      assign t2    = rp_ff[1][RECIP_FRAC_BITS +: CHAN_W];
      assign r_top = r_ff[RECIP_FRAC_BITS +: CHAN_W + 1];
      assign sat   = r_top[CHAN_W] ? {CHAN_W{1'b1}} : r_top[CHAN_W-1:0];

      always_ff @(posedge clock) begin
         if (en) begin
            pr_ff[0] <= PW'(dx2_ff) * PW'(px_q[0][SH +: CHAN_W]);
            pr_ff[1] <= PW'(dx1_ff) * PW'(px_q[1][SH +: CHAN_W]);
            pr_ff[2] <= PW'(dx2_ff) * PW'(px_q[2][SH +: CHAN_W]);
            pr_ff[3] <= PW'(dx1_ff) * PW'(px_q[3][SH +: CHAN_W]);
            sm_ff[0] <= SW'(pr_ff[0]) + SW'(pr_ff[1]);
            sm_ff[1] <= SW'(pr_ff[2]) + SW'(pr_ff[3]);
            rp_ff[0] <= RW'(rcp_ff[3]) * RW'(sm_ff[0]);
            rp_ff[1] <= RW'(rcp_ff[3]) * RW'(sm_ff[1]);
            dp_ff[0] <= PW'(dy2_ff[4]) * PW'(t1);
            dp_ff[1] <= PW'(dy1_ff[4]) * PW'(t2);
            s2_ff    <= SW'(dp_ff[0]) + SW'(dp_ff[1]);
            r_ff     <= RW'(rcp_ff[6]) * RW'(s2_ff);
            chan_ff  <= ok_ff[7] ? sat : '0;
         end
      end

      assign chan_out[c] = chan_ff;
   end

   logic rsp_ok_ff;

   // Load entries leave the pipe here without a result.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= v_ff[7] && (kind_ff[7] == KIND_COMPUTE);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_ok_ff <= ok_ff[7];
      end
   end

   assign in_pop    = pop;
   assign out_valid = rsp_valid_ff;
   assign out_ok    = rsp_ok_ff;
   assign out_red   = chan_out[0];
   assign out_green = chan_out[1];
   assign out_blue  = chan_out[2];

`include "perspective_warp_bilinear_assert.svh"
   `PWB_ASSERT(a_no_pop_on_stall, clock, reset, rsp_valid_ff && !out_ready |-> !pop, "entry popped while result stalled")
   `PWB_ASSERT(a_load_no_result, clock, reset, en && v_ff[7] && (kind_ff[7] == KIND_LOAD) |=> !rsp_valid_ff, "load produced a result")

endmodule

### rtl/core/perspective_warp_bilinear.sv
// Channel   Direction  Handshake               Payload
// req       in         req_valid / req_ready   kind, row, col, red/green/blue in
// rsp       out        rsp_valid / rsp_ready   valid_res, red/green/blue out
// csr       in         csr_we (no wait)        csr_index, csr_data
//
// One item enters per cycle while the queue is not full (req_ready); a compute item
// yields its result after passing through the front, the queue and the back pipeline.
// The front depth is set by the three restoring dividers, one quotient bit per stage.
// The back reads all four neighbors at once from four copies of the pixel store.
// Reset is synchronous and active high; it clears pipeline valids, queue and registers.
// A stalled rsp holds the back pipe; the queue then fills and drops req_ready.
module perspective_warp_bilinear import pwb_pkg::*; #(
   parameter int MAX_WIDTH       = DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT      = DEF_MAX_HEIGHT,
   parameter int RECIP_FRAC_BITS = DEF_RECIP_FRAC_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_kind,
   input  logic [POS_W-1:0]      req_row,
   input  logic [POS_W-1:0]      req_col,
   input  logic [CHAN_W-1:0]     req_red_in,
   input  logic [CHAN_W-1:0]     req_green_in,
   input  logic [CHAN_W-1:0]     req_blue_in,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  rsp_valid_res,
   output logic [CHAN_W-1:0]     rsp_red_out,
   output logic [CHAN_W-1:0]     rsp_green_out,
   output logic [CHAN_W-1:0]     rsp_blue_out,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   localparam int AW     = $clog2(MAX_WIDTH * MAX_HEIGHT);
   localparam int FW     = RECIP_FRAC_BITS + 1;
   localparam int DATA_W = 5 * AW + PIX_W + 5 * FW;
   localparam int FL_W   = $bits(pwb_flags_type);
   localparam int ENT_W  = FL_W + DATA_W;

   // Configuration registers
   logic [CSR_DATA_W-1:0] coef_a_ff, coef_b_ff, coef_c_ff, coef_d_ff;
   logic [COEF_W-1:0]     coef_last_ff;
   logic [FRAME_W-1:0]    frame_w_ff, frame_h_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_a_ff    <= RST_COEF_A;
         coef_b_ff    <= RST_COEF_B;
         coef_c_ff    <= RST_COEF_C;
         coef_d_ff    <= RST_COEF_D;
         coef_last_ff <= RST_COEF_LAST;
         frame_w_ff   <= RST_FRAME;
         frame_h_ff   <= RST_FRAME;
      end else if (csr_we) begin
         unique case (pwb_reg_type'(csr_index))
            REG_COEF_A:    coef_a_ff    <= csr_data;
            REG_COEF_B:    coef_b_ff    <= csr_data;
            REG_COEF_C:    coef_c_ff    <= csr_data;
            REG_COEF_D:    coef_d_ff    <= csr_data;
            REG_COEF_LAST: coef_last_ff <= csr_data[COEF_W-1:0];
            REG_FRAME_W:   frame_w_ff   <= csr_data[FRAME_W-1:0];
            REG_FRAME_H:   frame_h_ff   <= csr_data[FRAME_W-1:0];
            default: ;     // drop writes past the last register
         endcase
      end
   end

   // Unpack coefficient pairs, low half first.
   logic [NUM_COEF-1:0][COEF_W-1:0] coef;

   assign coef[0] = coef_a_ff[COEF_W-1:0];
   assign coef[1] = coef_a_ff[CSR_DATA_W-1:COEF_W];
   assign coef[2] = coef_b_ff[COEF_W-1:0];
   assign coef[3] = coef_b_ff[CSR_DATA_W-1:COEF_W];
   assign coef[4] = coef_c_ff[COEF_W-1:0];
   assign coef[5] = coef_c_ff[CSR_DATA_W-1:COEF_W];
   assign coef[6] = coef_d_ff[COEF_W-1:0];
   assign coef[7] = coef_d_ff[CSR_DATA_W-1:COEF_W];
   assign coef[8] = coef_last_ff;

   // Front: geometry and division; stalls as one block while the queue is full.
   logic              q_full, q_empty, q_pop;
   logic              fe_en;
   logic              fe_valid;
   pwb_flags_type     fe_flags;
   logic [DATA_W-1:0] fe_data;

   assign fe_en     = !q_full;
   assign req_ready = fe_en;

   pwb_front #(
      .MAX_WIDTH       (MAX_WIDTH),
      .MAX_HEIGHT      (MAX_HEIGHT),
      .RECIP_FRAC_BITS (RECIP_FRAC_BITS)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .enable       (fe_en),
      .in_valid     (req_valid && req_ready),
      .in_kind      (req_kind),
      .in_row       (req_row),
      .in_col       (req_col),
      .in_pixel     ({req_red_in, req_green_in, req_blue_in}),
      .coef         (coef),
      .frame_width  (frame_w_ff),
      .frame_height (frame_h_ff),
      .out_valid    (fe_valid),
      .out_flags    (fe_flags),
      .out_data     (fe_data)
   );

   // Queue between front and back; loads and computes stay in order.
   logic [ENT_W-1:0]  q_out;
   pwb_flags_type     be_flags;
   logic [DATA_W-1:0] be_data;

   pwb_queue #(.WIDTH(ENT_W)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (fe_en && fe_valid),
      .push_data ({fe_flags, fe_data}),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_out),
      .empty     (q_empty)
   );

   assign be_flags = pwb_flags_type'(q_out[ENT_W-1:DATA_W]);
   assign be_data  = q_out[DATA_W-1:0];

   // Back: store access, bilinear blend and result register.
   pwb_back #(
      .MAX_WIDTH       (MAX_WIDTH),
      .MAX_HEIGHT      (MAX_HEIGHT),
      .RECIP_FRAC_BITS (RECIP_FRAC_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (!q_empty),
      .in_flags  (be_flags),
      .in_data   (be_data),
      .in_pop    (q_pop),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_ok    (rsp_valid_res),
      .out_red   (rsp_red_out),
      .out_green (rsp_green_out),
      .out_blue  (rsp_blue_out)
   );

endmodule
